@@ design/fur_pkg.sv @@
// firmware update receiver: shared types and codes
// used by the top level; depends on nothing
package fur_pkg;

  // protocol phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_READY = 3'd1,
    PH_INIT  = 3'd2,
    PH_DATA  = 3'd3,
    PH_VALID = 3'd4
  } phase_t;

  // result sequencer
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_NOTICE = 3'd1,
    ST_PG_RD  = 3'd2,
    ST_PG_OUT = 3'd3,
    ST_SINGLE = 3'd4
  } seq_t;

  // input operation
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // control point commands
  localparam logic [2:0] CMD_INIT     = 3'd0;
  localparam logic [2:0] CMD_RECEIVE  = 3'd1;
  localparam logic [2:0] CMD_VALIDATE = 3'd2;
  localparam logic [2:0] CMD_ACTIVATE = 3'd3;
  localparam logic [2:0] CMD_RESET    = 3'd4;
  localparam logic [2:0] CMD_INTERVAL = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_RESP   = 3'd0;
  localparam logic [2:0] KIND_NOTICE = 3'd1;
  localparam logic [2:0] KIND_FLASH  = 3'd2;
  localparam logic [2:0] KIND_CLRKEY = 3'd3;
  localparam logic [2:0] KIND_ACT    = 3'd4;
  localparam logic [2:0] KIND_RADIO  = 3'd5;

  // response procedures
  localparam logic [1:0] PROC_START    = 2'd0;
  localparam logic [1:0] PROC_INIT     = 2'd1;
  localparam logic [1:0] PROC_RECEIVE  = 2'd2;
  localparam logic [1:0] PROC_VALIDATE = 2'd3;

  // packet position saturates here
  localparam logic [4:0] POS_MAX = 5'd31;

endpackage

@@ design/fur_if.sv @@
// firmware update receiver: valid/ready channels for input and result words
// no dependencies, not even on fur_pkg
interface fur_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  data_byte;
  logic        first_of_packet;
  logic        last_of_packet;
  logic [2:0]  command;
  logic [15:0] receipt_interval;

  modport source (output valid, op, data_byte, first_of_packet, last_of_packet, command,
                  receipt_interval, input ready);
  modport sink (input valid, op, data_byte, first_of_packet, last_of_packet, command,
                receipt_interval, output ready);
endinterface

interface fur_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  procedure;
  logic [31:0] byte_count;
  logic [15:0] flash_address;
  logic [63:0] flash_word;
  logic        page_commit;
  logic        last;

  modport source (output valid, kind, procedure, byte_count, flash_address, flash_word,
                  page_commit, last, input ready);
  modport sink (input valid, kind, procedure, byte_count, flash_address, flash_word,
                page_commit, last, output ready);
endinterface

@@ design/firmware_update_receiver.sv @@
// firmware update receiver top level: phase tracking, page buffer memory, result sequencer
// depends on fur_pkg and the channel interfaces in fur_if.sv
//
// Takes one word per handshake on in_ch: a data-packet byte (op 0) or a control
// command (op 1), and returns its results on out_ch in order, the final one
// flagged with last. Data bytes are kept in a page buffer memory of 64-bit
// words (PAGE_BYTES/8 rounded up) with a registered read; a byte is
// written into its lane as it is accepted, and a fill count tells which lanes
// hold live bytes, so the buffer needs no clearing pass after reset or after
// a page goes out. An item is taken only while the sequencer is idle;
// each plain result (response, receipt notice, clear key, activate, radio
// reset) is then loaded once the output register is free, and a page
// flush reads each flash word from the memory and then loads it into the
// output register. The output register lets a new word in while the
// last result of the previous one still waits at out_ch.
module firmware_update_receiver #(
  parameter int PAGE_BYTES = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  fur_in_if.sink          in_ch,
  fur_out_if.source       out_ch
);

  localparam int WORDS = (PAGE_BYTES + 7) / 8;
  localparam int WIDX  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FW    = $clog2(PAGE_BYTES + 1);
  localparam int CW    = (FW > WIDX + 3) ? FW : WIDX + 3;

  // architectural state
  fur_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]     image_size_r, image_size_nxt;
  logic [31:0]     bytes_r, bytes_nxt;
  logic [15:0]     interval_r, interval_nxt;
  logic [15:0]     countdown_r, countdown_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [15:0]     page_base_r, page_base_nxt;
  logic [4:0]      pos_r, pos_nxt;

  // results planned for the word in hand
  logic            pend_notice_r, pend_notice_nxt;
  logic [31:0]     notice_cnt_r, notice_cnt_nxt;
  logic            pend_page_r, pend_page_nxt;
  logic [FW-1:0]   page_cnt_r, page_cnt_nxt;
  logic [15:0]     page_addr_r, page_addr_nxt;
  logic            pend_single_r, pend_single_nxt;
  logic [2:0]      single_kind_r, single_kind_nxt;
  logic [1:0]      single_proc_r, single_proc_nxt;

  // sequencer and page buffer
  fur_pkg::seq_t   state_r, state_nxt;
  logic [WIDX-1:0] word_r;
  logic [63:0]     rd_data_r;
  logic [63:0]     buf_mem [WORDS];
  logic            wr_en;

  // output register
  logic            out_valid_r;
  logic [2:0]      out_kind_r;
  logic [1:0]      out_proc_r;
  logic [31:0]     out_count_r;
  logic [15:0]     out_addr_r;
  logic [63:0]     out_word_r;
  logic            out_commit_r;
  logic            out_last_r;

  // sequencer outputs
  logic            in_ready;
  logic            acc;
  logic            slot_free;
  logic            ld;
  logic [2:0]      ld_kind;
  logic [1:0]      ld_proc;
  logic [31:0]     ld_count;
  logic [15:0]     ld_addr;
  logic [63:0]     ld_word;
  logic            ld_commit;
  logic            ld_last;
  logic            word_adv;
  logic            last_word;
  logic [63:0]     masked_word;

  assign acc       = in_ch.valid && in_ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign last_word = (word_r == WIDX'(WORDS - 1));

  // ---------------------------------------------------------------------------
  // item decode: state update and result plan, evaluated on accept
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [4:0]    pos;
    logic [31:0]   img;
    logic [15:0]   cd;
    logic [FW-1:0] fill_inc;
    logic          match;

    phase_nxt       = phase_r;
    image_size_nxt  = image_size_r;
    bytes_nxt       = bytes_r;
    interval_nxt    = interval_r;
    countdown_nxt   = countdown_r;
    fill_nxt        = fill_r;
    page_base_nxt   = page_base_r;
    pos_nxt         = pos_r;
    pend_notice_nxt = pend_notice_r;
    notice_cnt_nxt  = notice_cnt_r;
    pend_page_nxt   = pend_page_r;
    page_cnt_nxt    = page_cnt_r;
    page_addr_nxt   = page_addr_r;
    pend_single_nxt = pend_single_r;
    single_kind_nxt = single_kind_r;
    single_proc_nxt = single_proc_r;
    wr_en           = 1'b0;
    pos             = '0;
    img             = '0;
    cd              = '0;
    fill_inc        = '0;
    match           = 1'b0;

    if (acc) begin
      pend_notice_nxt = 1'b0;
      pend_page_nxt   = 1'b0;
      pend_single_nxt = 1'b0;
      single_proc_nxt = fur_pkg::PROC_START;
      if (in_ch.op == fur_pkg::OP_DATA) begin
        pos     = in_ch.first_of_packet ? 5'd0 : pos_r;
        pos_nxt = (pos < fur_pkg::POS_MAX) ? pos + 5'd1 : fur_pkg::POS_MAX;
        unique case (phase_r)
          fur_pkg::PH_IDLE: begin
            // size field of the start packet, bytes 8 to 11, little-endian
            img = in_ch.first_of_packet ? 32'd0 : image_size_r;
            if (pos[4:2] == 3'd2) begin
              img[{pos[1:0], 3'b000} +: 8] = in_ch.data_byte;
            end
            image_size_nxt = img;
            if (in_ch.last_of_packet) begin
              pend_single_nxt = 1'b1;
              single_kind_nxt = fur_pkg::KIND_RESP;
              single_proc_nxt = fur_pkg::PROC_START;
              phase_nxt       = fur_pkg::PH_READY;
            end
          end
          fur_pkg::PH_INIT: begin
            if (in_ch.last_of_packet) begin
              pend_single_nxt = 1'b1;
              single_kind_nxt = fur_pkg::KIND_RESP;
              single_proc_nxt = fur_pkg::PROC_INIT;
            end
          end
          fur_pkg::PH_DATA: begin
            if (in_ch.first_of_packet && (interval_r != 16'd0)) begin
              cd = countdown_r - 16'd1;
              if (cd == 16'd0) begin
                cd              = interval_r;
                pend_notice_nxt = 1'b1;
                notice_cnt_nxt  = bytes_r;
              end
              countdown_nxt = cd;
            end
            wr_en     = 1'b1;
            fill_inc  = fill_r + FW'(1);
            bytes_nxt = bytes_r + 32'd1;
            match     = in_ch.last_of_packet && (bytes_nxt == image_size_r);
            // full page, or a partial one at completion (never empty here)
            if ((fill_inc == FW'(PAGE_BYTES)) || match) begin
              pend_page_nxt = 1'b1;
              page_cnt_nxt  = fill_inc;
              page_addr_nxt = page_base_r;
              page_base_nxt = page_base_r + 16'(PAGE_BYTES);
              fill_nxt      = '0;
            end else begin
              fill_nxt = fill_inc;
            end
            if (match) begin
              pend_single_nxt = 1'b1;
              single_kind_nxt = fur_pkg::KIND_RESP;
              single_proc_nxt = fur_pkg::PROC_RECEIVE;
            end
          end
          default: begin
            // bytes in ready or valid are dropped
          end
        endcase
      end else begin
        unique case (in_ch.command)
          fur_pkg::CMD_INIT: begin
            if (phase_r == fur_pkg::PH_READY) begin
              phase_nxt = fur_pkg::PH_INIT;
            end
          end
          fur_pkg::CMD_RECEIVE: begin
            if ((phase_r == fur_pkg::PH_READY) || (phase_r == fur_pkg::PH_INIT)) begin
              pend_single_nxt = 1'b1;
              single_kind_nxt = fur_pkg::KIND_CLRKEY;
              phase_nxt       = fur_pkg::PH_DATA;
            end
          end
          fur_pkg::CMD_VALIDATE: begin
            if (phase_r == fur_pkg::PH_DATA) begin
              if (bytes_r == image_size_r) begin
                pend_single_nxt = 1'b1;
                single_kind_nxt = fur_pkg::KIND_RESP;
                single_proc_nxt = fur_pkg::PROC_VALIDATE;
              end
              phase_nxt = fur_pkg::PH_VALID;
            end
          end
          fur_pkg::CMD_ACTIVATE: begin
            if (phase_r == fur_pkg::PH_VALID) begin
              pend_single_nxt = 1'b1;
              single_kind_nxt = fur_pkg::KIND_ACT;
            end
          end
          fur_pkg::CMD_RESET: begin
            pend_single_nxt = 1'b1;
            single_kind_nxt = fur_pkg::KIND_RADIO;
            phase_nxt       = fur_pkg::PH_IDLE;
          end
          fur_pkg::CMD_INTERVAL: begin
            interval_nxt  = in_ch.receipt_interval;
            countdown_nxt = in_ch.receipt_interval;
          end
          default: begin
            // unknown commands are dropped
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fur_pkg::ST_IDLE: begin
        if (acc) begin
          priority if (pend_notice_nxt) state_nxt = fur_pkg::ST_NOTICE;
          else if (pend_page_nxt)       state_nxt = fur_pkg::ST_PG_RD;
          else if (pend_single_nxt)     state_nxt = fur_pkg::ST_SINGLE;
          else                          state_nxt = fur_pkg::ST_IDLE;
        end
      end
      fur_pkg::ST_NOTICE: begin
        if (slot_free) begin
          priority if (pend_page_r) state_nxt = fur_pkg::ST_PG_RD;
          else if (pend_single_r)   state_nxt = fur_pkg::ST_SINGLE;
          else                      state_nxt = fur_pkg::ST_IDLE;
        end
      end
      fur_pkg::ST_PG_RD: begin
        state_nxt = fur_pkg::ST_PG_OUT;
      end
      fur_pkg::ST_PG_OUT: begin
        if (slot_free) begin
          priority if (!last_word) state_nxt = fur_pkg::ST_PG_RD;
          else if (pend_single_r)  state_nxt = fur_pkg::ST_SINGLE;
          else                     state_nxt = fur_pkg::ST_IDLE;
        end
      end
      fur_pkg::ST_SINGLE: begin
        if (slot_free) state_nxt = fur_pkg::ST_IDLE;
      end
      default: state_nxt = fur_pkg::ST_IDLE;
    endcase
  end

  // lanes at or beyond the fill count belong to a cleared buffer
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      masked_word[b*8 +: 8] = (CW'({word_r, 3'(b)}) < CW'(page_cnt_r)) ?
                              rd_data_r[b*8 +: 8] : 8'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    ld        = 1'b0;
    ld_kind   = fur_pkg::KIND_RESP;
    ld_proc   = fur_pkg::PROC_START;
    ld_count  = '0;
    ld_addr   = '0;
    ld_word   = '0;
    ld_commit = 1'b0;
    ld_last   = 1'b0;
    word_adv  = 1'b0;
    unique case (state_r)
      fur_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      fur_pkg::ST_NOTICE: begin
        ld       = slot_free;
        ld_kind  = fur_pkg::KIND_NOTICE;
        ld_count = notice_cnt_r;
        ld_last  = !pend_page_r && !pend_single_r;
      end
      fur_pkg::ST_PG_RD: begin
        // memory read of word_r in flight
      end
      fur_pkg::ST_PG_OUT: begin
        ld        = slot_free;
        word_adv  = slot_free;
        ld_kind   = fur_pkg::KIND_FLASH;
        ld_addr   = page_addr_r + 16'({word_r, 3'b000});
        ld_word   = masked_word;
        ld_commit = last_word;
        ld_last   = last_word && !pend_single_r;
      end
      fur_pkg::ST_SINGLE: begin
        ld      = slot_free;
        ld_kind = single_kind_r;
        ld_proc = single_proc_r;
        ld_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // page buffer: byte-lane write on accept, registered word read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[fill_r[WIDX+2:3]][{fill_r[2:0], 3'b000} +: 8] <= in_ch.data_byte;
    end
    rd_data_r <= buf_mem[word_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= fur_pkg::PH_IDLE;
      image_size_r  <= '0;
      bytes_r       <= '0;
      interval_r    <= '0;
      countdown_r   <= '0;
      fill_r        <= '0;
      page_base_r   <= '0;
      pos_r         <= '0;
      pend_notice_r <= 1'b0;
      pend_page_r   <= 1'b0;
      pend_single_r <= 1'b0;
      state_r       <= fur_pkg::ST_IDLE;
      word_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      image_size_r  <= image_size_nxt;
      bytes_r       <= bytes_nxt;
      interval_r    <= interval_nxt;
      countdown_r   <= countdown_nxt;
      fill_r        <= fill_nxt;
      page_base_r   <= page_base_nxt;
      pos_r         <= pos_nxt;
      pend_notice_r <= pend_notice_nxt;
      pend_page_r   <= pend_page_nxt;
      pend_single_r <= pend_single_nxt;
      state_r       <= state_nxt;
      if (word_adv) begin
        word_r <= last_word ? '0 : word_r + WIDX'(1);
      end
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    notice_cnt_r  <= notice_cnt_nxt;
    page_cnt_r    <= page_cnt_nxt;
    page_addr_r   <= page_addr_nxt;
    single_kind_r <= single_kind_nxt;
    single_proc_r <= single_proc_nxt;
    if (ld) begin
      out_kind_r   <= ld_kind;
      out_proc_r   <= ld_proc;
      out_count_r  <= ld_count;
      out_addr_r   <= ld_addr;
      out_word_r   <= ld_word;
      out_commit_r <= ld_commit;
      out_last_r   <= ld_last;
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.procedure     = out_proc_r;
  assign out_ch.byte_count    = out_count_r;
  assign out_ch.flash_address = out_addr_r;
  assign out_ch.flash_word    = out_word_r;
  assign out_ch.page_commit   = out_commit_r;
  assign out_ch.last          = out_last_r;

`ifndef SYNTHESIS
  // fill count never reaches a whole page between words
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FW'(PAGE_BYTES))
    else $error("page fill count out of range");

  // a flash word is output only after its buffer read state, or while it is held there
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fur_pkg::ST_PG_OUT) |->
      ($past(state_r) == fur_pkg::ST_PG_RD) || ($past(state_r) == fur_pkg::ST_PG_OUT))
    else $error("flash word output without a prior buffer read");

  // word counter rests at zero outside a page flush
  a_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fur_pkg::ST_IDLE) |-> (word_r == '0))
    else $error("word counter not reset after page flush");

  // a page commit closes a flash word run and is followed by nothing but a response
  a_commit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && ld_commit) |-> (ld_kind == fur_pkg::KIND_FLASH) && (state_nxt != fur_pkg::ST_PG_RD))
    else $error("page commit on a word that does not end the page");

  // no new word is taken while results of the last one are still queued
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ready || (!pend_notice_r && !pend_page_r && !pend_single_r))
    else $error("word accepted with results still pending");
`endif

endmodule
